@@ hdl/event_handler_filter_table_top_defines.svh @@
// assertion macros for the event handler filter table block
// included by the modules that carry concurrent assertions
`ifndef EVENT_HANDLER_FILTER_TABLE_TOP_DEFINES_SVH
`define EVENT_HANDLER_FILTER_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define EHFT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ehft assertion failed");
`define EHFT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ehft forbidden condition seen");
`else
`define EHFT_ASSERT(lbl, clk, rst_n, prop)
`define EHFT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/ehft_pkg.sv @@
// shared types and codes for the event handler filter table
// no dependencies
`default_nettype none
package ehft_pkg;

    localparam int NUM_TABLES = 3;
    localparam int RESULT_CAP = 16;
    localparam int KW         = 5;

    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_DISPATCH   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [1:0] XT_INT  = 2'd0;
    localparam logic [1:0] XT_BULK = 2'd1;
    localparam logic [1:0] XT_ISO  = 2'd2;
    localparam logic [1:0] TBL_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  table_sel;
        logic [15:0] handler_id;
        logic        use_filter;
        logic [7:0]  device_id;
        logic [7:0]  endpoint;
        logic [1:0]  trans_kind;
        logic        event_none;
        logic [7:0]  cookie;
    } t_in_req;

    typedef struct packed {
        logic [15:0] matched_id;
        logic        matched;
        logic [1:0]  status;
        logic        last;
    } t_out_rsp;

    typedef struct packed {
        logic [15:0] id;
        logic        filt;
        logic [7:0]  dev;
        logic [7:0]  ep;
        logic [1:0]  xtype;
    } t_entry;

    typedef enum logic [1:0] {
        CMD_REG,
        CMD_PURGE,
        CMD_DISPATCH,
        CMD_RESPOND
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [1:0] tbl;
        logic [1:0] status;
        t_in_req    req;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic pop;
    } t_back_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_P_START,
        S_P_CHK,
        S_P_MOVE,
        S_D_START,
        S_D_CHK,
        S_D_FIN
    } t_state;

endpackage
`default_nettype wire

@@ hdl/ehft_front.sv @@
// front end: takes requests, classifies them and queues commands
// depends on ehft_pkg
`default_nettype none
module ehft_front import ehft_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_req   i_in_req,
    input  wire t_back_ctl i_ctl,
    output t_q_stat        o_stat,
    output t_cmd           o_cmd
);

    t_cmd       w_cmd;
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd        = '0;
        w_cmd.req    = i_in_req;
        w_cmd.status = ST_DONE;
        w_cmd.tbl    = XT_INT;
        unique case (i_in_req.op)
            OP_REGISTER: begin
                w_cmd.kind = CMD_REG;
                if (i_in_req.trans_kind == XT_BULK || i_in_req.trans_kind == XT_ISO) begin
                    w_cmd.tbl = i_in_req.trans_kind;
                end
                if (!i_in_req.use_filter) begin
                    w_cmd.req.device_id = '0;
                    w_cmd.req.endpoint  = '0;
                end
            end
            OP_UNREGISTER: begin
                if (i_in_req.device_id == '0) begin
                    w_cmd.kind   = CMD_RESPOND;
                    w_cmd.status = ST_IGNORED;
                end else begin
                    w_cmd.kind = CMD_PURGE;
                end
            end
            OP_DISPATCH: begin
                if (i_in_req.table_sel == TBL_NONE) begin
                    w_cmd.kind   = CMD_RESPOND;
                    w_cmd.status = ST_IGNORED;
                end else if (i_in_req.event_none) begin
                    w_cmd.kind = CMD_RESPOND;
                end else begin
                    w_cmd.kind = CMD_DISPATCH;
                    w_cmd.tbl  = i_in_req.table_sel;
                end
            end
            default: begin
                w_cmd.kind   = CMD_RESPOND;
                w_cmd.status = ST_IGNORED;
            end
        endcase
    end

    assign o_in_stall       = (r_cnt == 2'd2);
    assign w_push           = i_in_valid && !o_in_stall;
    assign w_pop            = i_ctl.pop && (r_cnt != 2'd0);
    assign o_stat.not_empty = (r_cnt != 2'd0);
    assign o_stat.full      = o_in_stall;
    assign o_cmd            = r_q[r_rp];

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

@@ hdl/ehft_back.sv @@
// back end: handler table memory, counts and the walking sequencer
// depends on ehft_pkg and the assertion macro header
`default_nettype none
`include "event_handler_filter_table_top_defines.svh"
module ehft_back import ehft_pkg::*; #(
    parameter int MAX_HANDLERS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_stat,
    input  wire t_cmd    i_cmd,
    output t_back_ctl    o_ctl,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_rsp     o_out_rsp
);

    localparam int CW    = $clog2(MAX_HANDLERS + 1);
    localparam int IW    = (MAX_HANDLERS > 1) ? $clog2(MAX_HANDLERS) : 1;
    localparam int DEPTH = NUM_TABLES * MAX_HANDLERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_entry        mem [DEPTH];
    t_entry        r_rdata;

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [CW-1:0] r_cnt [NUM_TABLES];
    logic [CW-1:0] n_cnt [NUM_TABLES];
    logic [1:0]    r_t, n_t;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_n, n_n;
    logic [KW-1:0] r_k, n_k;
    logic          r_pend_v, n_pend_v;
    logic [15:0]   r_pend_id, n_pend_id;
    logic          r_ovalid, n_ovalid;
    t_out_rsp      r_orsp, n_orsp;

    logic          w_we, w_re, w_emit, w_free, w_hit;
    logic [AW-1:0] w_waddr, w_raddr;
    t_entry        w_wdata;
    t_out_rsp      w_emit_rsp;
    logic          w_cnt_ok;

    function automatic logic [AW-1:0] f_addr(logic [1:0] t, logic [CW-1:0] idx);
        return AW'(AW'(t) * AW'(MAX_HANDLERS)) + AW'(idx[IW-1:0]);
    endfunction

    assign w_free = !r_ovalid || !i_out_stall;

    // event filter against the entry just read
    always_comb begin
        w_hit = (r_rdata.id != '0);
        if (r_rdata.filt) begin
            if (r_rdata.xtype != r_cmd.req.trans_kind) w_hit = 1'b0;
            if (r_rdata.dev != '0 && r_rdata.dev != r_cmd.req.device_id) w_hit = 1'b0;
            if (r_rdata.ep != '0 && r_rdata.ep != r_cmd.req.endpoint) w_hit = 1'b0;
            if (r_cmd.req.cookie != '0 && r_rdata.dev != '0 &&
                r_cmd.req.cookie != r_rdata.dev) w_hit = 1'b0;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_cnt      = r_cnt;
        n_t        = r_t;
        n_i        = r_i;
        n_n        = r_n;
        n_k        = r_k;
        n_pend_v   = r_pend_v;
        n_pend_id  = r_pend_id;
        o_ctl.pop  = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = '0;
        w_raddr    = '0;
        w_wdata    = r_rdata;
        w_emit     = 1'b0;
        w_emit_rsp = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.not_empty) begin
                    o_ctl.pop = 1'b1;
                    n_cmd     = i_cmd;
                    case (i_cmd.kind)
                        CMD_REG: begin
                            if (r_cnt[i_cmd.tbl] >= CW'(MAX_HANDLERS)) begin
                                n_cmd.status = ST_FULL;
                            end else begin
                                w_we          = 1'b1;
                                w_waddr       = f_addr(i_cmd.tbl, r_cnt[i_cmd.tbl]);
                                w_wdata.id    = i_cmd.req.handler_id;
                                w_wdata.filt  = i_cmd.req.use_filter;
                                w_wdata.dev   = i_cmd.req.device_id;
                                w_wdata.ep    = i_cmd.req.endpoint;
                                w_wdata.xtype = i_cmd.req.trans_kind;
                                n_cnt[i_cmd.tbl] = r_cnt[i_cmd.tbl] + CW'(1);
                            end
                            n_state = S_RESP;
                        end
                        CMD_PURGE: begin
                            n_t     = 2'd0;
                            n_i     = '0;
                            n_n     = r_cnt[0];
                            n_state = S_P_START;
                        end
                        CMD_DISPATCH: begin
                            n_i      = '0;
                            n_n      = r_cnt[i_cmd.tbl];
                            n_k      = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_D_START;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_RESP: begin
                if (w_free) begin
                    w_emit            = 1'b1;
                    w_emit_rsp.status = r_cmd.status;
                    w_emit_rsp.last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_P_START: begin
                if (r_i < r_n) begin
                    w_re    = 1'b1;
                    w_raddr = f_addr(r_t, r_i);
                    n_state = S_P_CHK;
                end else begin
                    n_cnt[r_t] = r_n;
                    if (r_t == 2'(NUM_TABLES - 1)) begin
                        n_state = S_RESP;
                    end else begin
                        n_t = r_t + 2'd1;
                        n_i = '0;
                        n_n = r_cnt[r_t + 2'd1];
                    end
                end
            end
            S_P_CHK: begin
                if (r_rdata.filt && r_rdata.dev == r_cmd.req.device_id) begin
                    w_re    = 1'b1;
                    w_raddr = f_addr(r_t, r_n - CW'(1));
                    n_state = S_P_MOVE;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_P_START;
                end
            end
            S_P_MOVE: begin
                w_we    = 1'b1;
                w_waddr = f_addr(r_t, r_i);
                w_wdata = r_rdata;
                n_n     = r_n - CW'(1);
                n_state = S_P_START;
            end
            S_D_START: begin
                if (r_i < r_n && r_k < KW'(RESULT_CAP)) begin
                    w_re    = 1'b1;
                    w_raddr = f_addr(r_cmd.tbl, r_i);
                    n_state = S_D_CHK;
                end else begin
                    n_state = S_D_FIN;
                end
            end
            S_D_CHK: begin
                if (w_hit) begin
                    if (!r_pend_v || w_free) begin
                        if (r_pend_v) begin
                            w_emit                = 1'b1;
                            w_emit_rsp.matched_id = r_pend_id;
                            w_emit_rsp.matched    = 1'b1;
                            w_emit_rsp.status     = ST_DONE;
                        end
                        n_pend_v  = 1'b1;
                        n_pend_id = r_rdata.id;
                        n_k       = r_k + KW'(1);
                        n_i       = r_i + CW'(1);
                        n_state   = S_D_START;
                    end
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_D_START;
                end
            end
            S_D_FIN: begin
                if (w_free) begin
                    w_emit                = 1'b1;
                    w_emit_rsp.matched_id = r_pend_v ? r_pend_id : 16'd0;
                    w_emit_rsp.matched    = r_pend_v;
                    w_emit_rsp.status     = ST_DONE;
                    w_emit_rsp.last       = 1'b1;
                    n_pend_v              = 1'b0;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_orsp   = r_orsp;
        n_ovalid = r_ovalid;
        if (w_emit) begin
            n_ovalid = 1'b1;
            n_orsp   = w_emit_rsp;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_rsp   = r_orsp;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_t       <= n_t;
        r_i       <= n_i;
        r_n       <= n_n;
        r_pend_id <= n_pend_id;
        r_orsp    <= n_orsp;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '{default: '0};
            r_k      <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_k      <= n_k;
            r_pend_v <= n_pend_v;
            r_ovalid <= n_ovalid;
        end
    end

    // every table count stays within the table size
    assign w_cnt_ok = r_cnt[0] <= CW'(MAX_HANDLERS) && r_cnt[1] <= CW'(MAX_HANDLERS) &&
                      r_cnt[2] <= CW'(MAX_HANDLERS);

    `EHFT_ASSERT(a_cnt_bound, i_clk, i_rst_n, w_cnt_ok)
    `EHFT_ASSERT(a_k_cap, i_clk, i_rst_n, r_k <= KW'(RESULT_CAP))
    `EHFT_NEVER(a_pend_without_count, i_clk, i_rst_n, r_pend_v && r_k == '0)
    `EHFT_ASSERT(a_move_nonempty, i_clk, i_rst_n, (r_state == S_P_MOVE) |-> (r_n != '0))
    `EHFT_NEVER(a_full_and_empty, i_clk, i_rst_n, i_stat.full && !i_stat.not_empty)

endmodule
`default_nettype wire

@@ hdl/event_handler_filter_table_top.sv @@
// top level of the event handler filter table
// depends on ehft_pkg, ehft_front and ehft_back
//
// channel   direction  handshake                    payload
// request   in         i_in_valid / o_in_stall      i_in_req  (t_in_req)
// result    out        o_out_valid / i_out_stall    o_out_rsp (t_out_rsp)
//
// register and ignored requests go from the queue through S_IDLE and S_RESP
// unregister walks all three tables, moving a table's last entry into the slot of
// each removed one; bound by the single table memory read port
// dispatch reads and filters the entries in turn; at most MAX_HANDLERS entries
// a two-deep command queue lets requests be taken while the back end is busy
// synchronous active-low reset clears counts and control; table memory is not
// cleared, only entries below a table's count are ever read
`default_nettype none
module event_handler_filter_table_top import ehft_pkg::*; #(
    parameter int MAX_HANDLERS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    // request channel
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in_req i_in_req,
    // result channel
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_rsp     o_out_rsp
);

    // front to back command queue status and pop
    t_q_stat   w_stat;
    t_cmd      w_cmd;
    t_back_ctl w_ctl;

    // classifies each request and holds it until the back end is free
    ehft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .i_ctl      (w_ctl),
        .o_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // owns the tables, walks them and drives the result register
    ehft_back #(
        .MAX_HANDLERS (MAX_HANDLERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (w_stat),
        .i_cmd       (w_cmd),
        .o_ctl       (w_ctl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

endmodule
`default_nettype wire
